### design/t3br_pkg.sv
// types and constants shared by the top-3 ratio selector
// no dependencies; used by top3_best_ratio_select

package t3br_pkg;

    // field widths of the item and result transfers
    localparam int VALUE_BITS = 20;
    localparam int INDEX_BITS = 15;
    localparam int TOTAL_BITS = VALUE_BITS + 2;
    localparam int PROD_BITS  = 2 * VALUE_BITS;
    localparam int SLOTS      = 3;

    // one input item
    typedef struct packed {
        logic [VALUE_BITS-1:0] joy;
        logic [VALUE_BITS-1:0] price;
        logic                  last;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic [TOTAL_BITS-1:0] total_price;
        logic [INDEX_BITS-1:0] first_index;
        logic [INDEX_BITS-1:0] second_index;
        logic [INDEX_BITS-1:0] third_index;
        logic [1:0]            found;
        logic                  error;
    } t_out_item;

    // one kept slot
    typedef struct packed {
        logic [VALUE_BITS-1:0] joy;
        logic [VALUE_BITS-1:0] price;
        logic [INDEX_BITS-1:0] number;
    } t_slot;

endpackage

### design/top3_best_ratio_select.sv
// top-3 lowest price/joy ratio selector over a run of items
// depends on t3br_pkg for the transfer and slot types
//
// channel   direction  handshake                      payload
// in        input      i_in_valid  / o_in_stall       i_in_item  (t_in_item)
// out       output     o_out_valid / i_out_stall      o_out_item (t_out_item)
//
// one item per cycle unless a last item waits for the result register: an item
// sits in the input register, where the three cross-multiply compares and the slot
// insert work on it; the last item of a run then writes the result register.
// reset clears slot valid bits, item counter, error flag and both valid flags.
// a waiting result stalls only a last item (and the input behind it); other items keep flowing.

module top3_best_ratio_select (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t3br_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t3br_pkg::t_out_item o_out_item
);

    localparam logic [t3br_pkg::INDEX_BITS-1:0] CNT_MAX = '1;

    logic                r_in_valid;
    t3br_pkg::t_in_item  r_in;
    logic                r_out_valid;
    t3br_pkg::t_out_item r_out;

    t3br_pkg::t_slot r_slot [t3br_pkg::SLOTS];
    logic [t3br_pkg::SLOTS-1:0]     r_valid;
    logic [t3br_pkg::INDEX_BITS-1:0] r_cnt;
    logic                            r_bad;

    t3br_pkg::t_slot n_slot [t3br_pkg::SLOTS];
    logic [t3br_pkg::SLOTS-1:0]     n_valid;
    logic [t3br_pkg::INDEX_BITS-1:0] n_cnt;
    logic                            n_bad;
    t3br_pkg::t_out_item             n_out;

    logic                            advance;
    logic                            in_take;
    logic                            zero_item;
    logic [t3br_pkg::SLOTS-1:0]     hit;
    logic [t3br_pkg::SLOTS-1:0]     earlier;
    logic [t3br_pkg::PROD_BITS-1:0] prod_new [t3br_pkg::SLOTS];
    logic [t3br_pkg::PROD_BITS-1:0] prod_old [t3br_pkg::SLOTS];
    t3br_pkg::t_slot                 new_slot;

    // handshake: a last item waits only for a free result register
    assign advance    = r_in_valid && (!r_in.last || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    // saturating item number and zero-item check
    assign n_cnt     = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 1'b1;
    assign zero_item = (r_in.joy == '0) && (r_in.price == '0);
    assign new_slot  = '{joy: r_in.joy, price: r_in.price, number: n_cnt};

    // cross-multiply compares against each kept slot
    always_comb begin
        for (int k = 0; k < t3br_pkg::SLOTS; k++) begin
            prod_new[k] = t3br_pkg::PROD_BITS'(r_in.price) *
                          t3br_pkg::PROD_BITS'(r_slot[k].joy);
            prod_old[k] = t3br_pkg::PROD_BITS'(r_slot[k].price) *
                          t3br_pkg::PROD_BITS'(r_in.joy);
            hit[k]      = !zero_item && (!r_valid[k] || (prod_new[k] < prod_old[k]));
        end
        earlier[0] = 1'b0;
        for (int k = 1; k < t3br_pkg::SLOTS; k++) begin
            earlier[k] = earlier[k-1] || hit[k-1];
        end
    end

    // sorted insert: first hit takes the item, slots behind it shift down
    always_comb begin
        if (hit[0]) begin
            n_slot[0]  = new_slot;
            n_valid[0] = 1'b1;
        end else begin
            n_slot[0]  = r_slot[0];
            n_valid[0] = r_valid[0];
        end
        for (int k = 1; k < t3br_pkg::SLOTS; k++) begin
            if (earlier[k]) begin
                n_slot[k]  = r_slot[k-1];
                n_valid[k] = r_valid[k-1];
            end else if (hit[k]) begin
                n_slot[k]  = new_slot;
                n_valid[k] = 1'b1;
            end else begin
                n_slot[k]  = r_slot[k];
                n_valid[k] = r_valid[k];
            end
        end
        n_bad = r_bad || zero_item;
    end

    // result from the updated slots
    always_comb begin
        n_out.total_price = '0;
        for (int k = 0; k < t3br_pkg::SLOTS; k++) begin
            if (n_valid[k]) begin
                n_out.total_price = n_out.total_price +
                                    t3br_pkg::TOTAL_BITS'(n_slot[k].price);
            end
        end
        n_out.first_index  = n_valid[0] ? n_slot[0].number : '0;
        n_out.second_index = n_valid[1] ? n_slot[1].number : '0;
        n_out.third_index  = n_valid[2] ? n_slot[2].number : '0;
        n_out.found        = 2'(n_valid[0]) + 2'(n_valid[1]) + 2'(n_valid[2]);
        n_out.error        = n_bad;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (in_take) begin
            r_in <= i_in_item;
        end
    end

    // slot state, counter and error flag; a last item returns them to reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_cnt   <= '0;
            r_bad   <= 1'b0;
        end else if (advance) begin
            if (r_in.last) begin
                r_valid <= '0;
                r_cnt   <= '0;
                r_bad   <= 1'b0;
            end else begin
                r_valid <= n_valid;
                r_cnt   <= n_cnt;
                r_bad   <= n_bad;
            end
        end
        if (advance) begin
            for (int k = 0; k < t3br_pkg::SLOTS; k++) begin
                r_slot[k] <= n_slot[k];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (advance && r_in.last) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

### dv/top3_best_ratio_select_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for top3_best_ratio_select: directed runs,
// back-pressure and random runs; depends on t3br_pkg and the rtl

module top3_best_ratio_select_tb;

    localparam int unsigned VALUE_MAX  = (1 << t3br_pkg::VALUE_BITS) - 1;
    localparam int unsigned INDEX_MAX  = (1 << t3br_pkg::INDEX_BITS) - 1;
    localparam int          IDLE_LIMIT = 2000;
    localparam int          HOLD_CYCLES = 150;
    localparam int          RANDOM_ITEMS = 470;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                i_out_stall = 1'b0;
    t3br_pkg::t_in_item  i_in_item   = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    t3br_pkg::t_out_item o_out_item;

    top3_best_ratio_select dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // predicted top-3 slots and run state
    t3br_pkg::t_slot                 kept [t3br_pkg::SLOTS];
    bit                              kept_valid [t3br_pkg::SLOTS];
    logic [t3br_pkg::INDEX_BITS-1:0] run_count;
    bit                              run_error;

    t3br_pkg::t_in_item  pending_items [$];
    t3br_pkg::t_out_item expected_results [$];
    int unsigned queued_items   = 0;
    int unsigned accepted_items = 0;
    int unsigned fail_count     = 0;
    int unsigned results_seen   = 0;
    bit          no_gaps        = 1'b0;
    bit          rx_hold_armed  = 1'b0;
    bit          rx_hold_done   = 1'b0;
    int          hold_left      = 0;
    int          idle_cycles    = 0;

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input longint unsigned got,
                               input longint unsigned want);
        if (got != want)
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      results_seen, name, got, want));
    endtask

    task automatic clear_run();
        for (int k = 0; k < t3br_pkg::SLOTS; k++) begin
            kept[k]       = '0;
            kept_valid[k] = 1'b0;
        end
        run_count = '0;
        run_error = 1'b0;
    endtask

    // strictly lower price/joy ratio, by exact cross-multiplication
    function automatic bit lower_ratio(input logic [t3br_pkg::VALUE_BITS-1:0] joy,
                                       input logic [t3br_pkg::VALUE_BITS-1:0] price,
                                       input t3br_pkg::t_slot other);
        logic [t3br_pkg::PROD_BITS-1:0] lhs;
        logic [t3br_pkg::PROD_BITS-1:0] rhs;
        lhs = t3br_pkg::PROD_BITS'(price) * t3br_pkg::PROD_BITS'(other.joy);
        rhs = t3br_pkg::PROD_BITS'(other.price) * t3br_pkg::PROD_BITS'(joy);
        return lhs < rhs;
    endfunction

    // update the top-3 with one accepted item, queue the result on last
    task automatic rank_item(input t3br_pkg::t_in_item item);
        int                              pos;
        t3br_pkg::t_out_item             res;
        logic [t3br_pkg::TOTAL_BITS-1:0] sum;
        logic [1:0]                      cnt;
        logic [t3br_pkg::INDEX_BITS-1:0] idx [t3br_pkg::SLOTS];
        if (run_count != INDEX_MAX[t3br_pkg::INDEX_BITS-1:0])
            run_count++;
        if (item.joy == '0 && item.price == '0) begin
            run_error = 1'b1;
        end else begin
            pos = t3br_pkg::SLOTS;
            for (int k = 0; k < t3br_pkg::SLOTS; k++) begin
                if (pos == t3br_pkg::SLOTS &&
                    (!kept_valid[k] || lower_ratio(item.joy, item.price, kept[k])))
                    pos = k;
            end
            if (pos < t3br_pkg::SLOTS) begin
                for (int k = t3br_pkg::SLOTS - 1; k > pos; k--) begin
                    kept[k]       = kept[k-1];
                    kept_valid[k] = kept_valid[k-1];
                end
                kept[pos].joy    = item.joy;
                kept[pos].price  = item.price;
                kept[pos].number = run_count;
                kept_valid[pos]  = 1'b1;
            end
        end
        if (item.last) begin
            sum = '0;
            cnt = '0;
            for (int k = 0; k < t3br_pkg::SLOTS; k++) begin
                idx[k] = '0;
                if (kept_valid[k]) begin
                    sum += t3br_pkg::TOTAL_BITS'(kept[k].price);
                    cnt++;
                    idx[k] = kept[k].number;
                end
            end
            res.total_price  = sum;
            res.first_index  = idx[0];
            res.second_index = idx[1];
            res.third_index  = idx[2];
            res.found        = cnt;
            res.error        = run_error;
            expected_results.push_back(res);
            clear_run();
        end
    endtask

    task automatic push_item(input int unsigned joy, input int unsigned price, input bit last);
        t3br_pkg::t_in_item item;
        item.joy   = joy[t3br_pkg::VALUE_BITS-1:0];
        item.price = price[t3br_pkg::VALUE_BITS-1:0];
        item.last  = last;
        pending_items.push_back(item);
        queued_items++;
    endtask

    // sender pause: wait until every item is taken and every result is back
    task automatic drain();
        while (accepted_items != queued_items || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // one run of random items, mixing ties, zeros, extremes and full range
    task automatic push_random_run(input int len);
        int unsigned j, p, kind, m;
        for (int n = 0; n < len; n++) begin
            kind = $urandom_range(99);
            if (kind < 4) begin
                j = 0;
                p = 0;
            end else if (kind < 10) begin
                j = 0;
                p = $urandom;
            end else if (kind < 16) begin
                j = $urandom;
                p = 0;
            end else if (kind < 40) begin
                j = $urandom_range(7);
                p = $urandom_range(7);
            end else if (kind < 55) begin
                m = $urandom_range(1, 60000);
                j = $urandom_range(1, 15) * m;
                p = $urandom_range(1, 15) * m;
            end else if (kind < 65) begin
                j = $urandom_range(1) ? VALUE_MAX : $urandom_range(1, 2);
                p = $urandom_range(1) ? VALUE_MAX : $urandom_range(0, 2);
            end else begin
                j = $urandom;
                p = $urandom;
            end
            push_item(j, p, n == len - 1);
        end
    endtask

    // reset and stimulus
    initial begin
        int unsigned random_items;
        int          len;
        clear_run();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single items, extremes and a lone bad item
        push_item(VALUE_MAX, VALUE_MAX, 1'b1);
        push_item(0, 0, 1'b1);
        push_item(1, VALUE_MAX, 1'b1);
        // zero joy counts as infinite ratio but still fills an empty slot
        push_item(0, 5, 1'b0);
        push_item(7, 0, 1'b0);
        push_item(VALUE_MAX, VALUE_MAX, 1'b0);
        push_item(1, VALUE_MAX, 1'b1);
        // equal ratios keep the earlier item
        push_item(2, 4, 1'b0);
        push_item(1, 2, 1'b0);
        push_item(3, 6, 1'b0);
        push_item(4, 8, 1'b1);
        // bad item in the middle uses a number, sets the error flag
        push_item(5, 5, 1'b0);
        push_item(0, 0, 1'b0);
        push_item(1, 1, 1'b1);
        // insertion at every slot position
        push_item(10, 10, 1'b0);
        push_item(10, 20, 1'b0);
        push_item(10, 5, 1'b0);
        push_item(10, 15, 1'b0);
        push_item(10, 1, 1'b1);
        // zero price ties
        push_item(1, 0, 1'b0);
        push_item(VALUE_MAX, 0, 1'b0);
        push_item(3, 0, 1'b1);
        drain();

        // back-pressure: receiver holds off while short runs keep coming
        rx_hold_armed = 1'b1;
        for (int n = 0; n < 30; n++)
            push_random_run($urandom_range(1, 3));
        drain();

        // random runs, the first stretch with no idling on either side
        random_items = 0;
        no_gaps = 1'b1;
        while (random_items < RANDOM_ITEMS) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
            push_random_run(len);
            random_items += len;
            if (random_items > 150 && no_gaps) begin
                drain();
                no_gaps = 1'b0;
            end
            if ($urandom_range(15) == 0)
                drain();
        end
        drain();
        repeat (10) @(posedge i_clk);

        if (fail_count == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // driver: hold the item until it transfers, then offer the next or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                rank_item(i_in_item);
                accepted_items++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_items.size() != 0 && (no_gaps || $urandom_range(99) >= 8)) begin
                    i_in_item  <= pending_items.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result transfer, drive stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              results_seen));
                end else begin
                    check_field("total_price", o_out_item.total_price,
                                expected_results[0].total_price);
                    check_field("first_index", o_out_item.first_index,
                                expected_results[0].first_index);
                    check_field("second_index", o_out_item.second_index,
                                expected_results[0].second_index);
                    check_field("third_index", o_out_item.third_index,
                                expected_results[0].third_index);
                    check_field("found", o_out_item.found, expected_results[0].found);
                    check_field("error", o_out_item.error, expected_results[0].error);
                    void'(expected_results.pop_front());
                end
            end
            // one long hold-off, counted here
            if (rx_hold_armed && !rx_hold_done) begin
                rx_hold_done = 1'b1;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !no_gaps && ($urandom_range(99) < 8);
            end
        end
    end

    // watchdog: too long with no transfer on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
